### rtl/lpe_pkg.sv
package lpe_pkg;

	localparam int unsigned POS_W = 17;
	localparam int unsigned LEN_W = 16;
	localparam int unsigned LFSR_W = 16;
	localparam int unsigned PIX_W = 8;

	localparam logic [POS_W-1:0] POS_MAX = '1;
	localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;
	localparam logic [PIX_W-1:0] DARK_MASK = 8'h29;
	localparam logic [PIX_W-1:0] BLUE_KEEP = 8'hF8;
	localparam logic [PIX_W-1:0] GREEN_KEEP = 8'hFC;
	localparam logic [PIX_W-1:0] RED_KEEP = 8'hF8;

	typedef enum logic [1:0] {
		CFG_PAYLOAD_LENGTH,
		CFG_FILL_MODE,
		CFG_RANDOM_SEED
	} cfg_index_t;

	typedef enum logic [1:0] {
		FILL_NONE,
		FILL_RANDOM,
		FILL_DARK,
		FILL_LIGHT
	} fill_mode_t;

	typedef struct packed {
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
		logic             used;
	} result_t;

	typedef struct packed {
		logic             frame_start;
		logic [PIX_W-1:0] blue;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] payload;
	} pixel_t;

	function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
		logic [LFSR_W-1:0] s;
		s = v >> 1;
		if (v[0]) begin
			s = s ^ LFSR_TAPS;
		end
		return s;
	endfunction

	function automatic logic [LFSR_W-1:0] seed_fix(input logic [LFSR_W-1:0] s);
		return (s == '0) ? {{(LFSR_W-1){1'b0}}, 1'b1} : s;
	endfunction

endpackage

### rtl/lpe_embed_calc.sv
module lpe_embed_calc import lpe_pkg::*; (
	input  pixel_t            pixel,
	input  logic [POS_W-1:0]  pos,
	input  logic [LFSR_W-1:0] lfsr,
	input  logic [LEN_W-1:0]  payload_length,
	input  fill_mode_t        fill_mode,
	input  logic [LFSR_W-1:0] random_seed,
	output result_t           result,
	output logic [POS_W-1:0]  pos_next,
	output logic [LFSR_W-1:0] lfsr_next
);

	logic [POS_W-1:0]  pos_eff;
	logic [LFSR_W-1:0] lfsr_eff;
	logic [LFSR_W-1:0] lfsr_adv;
	logic [POS_W-1:0]  limit;
	logic [PIX_W-1:0]  hidden;
	logic              embed;
	logic              used;

	assign pos_eff = pixel.frame_start ? '0 : pos;
	assign lfsr_eff = pixel.frame_start ? seed_fix(random_seed) : lfsr;
	assign lfsr_adv = lfsr_step(lfsr_eff);
	assign limit = {1'b0, payload_length} + POS_W'(2);

	always_comb begin
		hidden = '0;
		embed = 1'b1;
		used = 1'b0;
		lfsr_next = lfsr_eff;
		priority if (pos_eff == POS_W'(0)) begin
			hidden = payload_length[7:0];
		end else if (pos_eff == POS_W'(1)) begin
			hidden = payload_length[15:8];
		end else if (pos_eff < limit) begin
			hidden = pixel.payload;
			used = 1'b1;
		end else begin
			unique case (fill_mode)
				FILL_NONE: begin
					embed = 1'b0;
				end
				FILL_RANDOM: begin
					lfsr_next = lfsr_adv;
					hidden = lfsr_adv[7:0];
				end
				FILL_DARK: begin
					lfsr_next = lfsr_adv;
					hidden = lfsr_adv[7:0] & DARK_MASK;
				end
				FILL_LIGHT: begin
					lfsr_next = lfsr_adv;
					hidden = lfsr_adv[7:0] | ~DARK_MASK;
				end
				default: begin
					embed = 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		result.used = used;
		if (embed) begin
			result.blue = (pixel.blue & BLUE_KEEP) | {5'b0, hidden[2:0]};
			result.green = (pixel.green & GREEN_KEEP) | {6'b0, hidden[4:3]};
			result.red = (pixel.red & RED_KEEP) | {5'b0, hidden[7:5]};
		end else begin
			result.blue = pixel.blue;
			result.green = pixel.green;
			result.red = pixel.red;
		end
	end

	assign pos_next = (pos_eff < POS_MAX) ? pos_eff + POS_W'(1) : pos_eff;

endmodule

### rtl/lpe_out_fifo.sv
module lpe_out_fifo import lpe_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	input  logic    pop,
	output logic    valid,
	output logic    full,
	output result_t data
);

	result_t    mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign valid = (count_q != 2'd0);
	assign full = (count_q == 2'd2);
	assign data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### rtl/lsb_pixel_embed.sv
// Hides one byte per 24-bit pixel in the low color bits (blue 3, green 2, red 3). The first two
// pixels of a frame carry the payload length, the next payload_length pixels carry payload_byte,
// and later pixels are filled per fill_mode from a 16-bit LFSR. One pixel is taken per clock
// while the result side does not stall; each pixel passes the input register, then a two-entry
// result buffer that absorbs stalls on the result side, before its result is offered.
// Configuration writes are always ready and take effect on the next pixel; the seed is loaded
// at frame_start.
module lsb_pixel_embed import lpe_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             pixel_valid,
	output logic             pixel_stall,
	input  logic             frame_start,
	input  logic [PIX_W-1:0] blue_in,
	input  logic [PIX_W-1:0] green_in,
	input  logic [PIX_W-1:0] red_in,
	input  logic [PIX_W-1:0] payload_byte,
	output logic             result_valid,
	input  logic             result_stall,
	output logic [PIX_W-1:0] blue_out,
	output logic [PIX_W-1:0] green_out,
	output logic [PIX_W-1:0] red_out,
	output logic             used_payload,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [LEN_W-1:0] cfg_data
);

	logic [LEN_W-1:0]  payload_length_q;
	fill_mode_t        fill_mode_q;
	logic [LFSR_W-1:0] random_seed_q;
	logic [POS_W-1:0]  pos_q;
	logic [LFSR_W-1:0] lfsr_q;

	logic              valid_s1;
	pixel_t            pixel_s1;

	result_t           calc_result;
	logic [POS_W-1:0]  pos_next;
	logic [LFSR_W-1:0] lfsr_next;
	result_t           fifo_data;
	logic              fifo_full;
	logic              pop;
	logic              adv_s1;
	logic              accept;

	assign cfg_ready = 1'b1;
	assign pop = result_valid && !result_stall;
	assign adv_s1 = valid_s1 && (!fifo_full || pop);
	assign pixel_stall = valid_s1 && !adv_s1;
	assign accept = pixel_valid && !pixel_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_length_q <= LEN_W'(1);
			fill_mode_q <= FILL_NONE;
			random_seed_q <= LFSR_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_PAYLOAD_LENGTH: payload_length_q <= cfg_data;
				CFG_FILL_MODE: fill_mode_q <= fill_mode_t'(cfg_data[1:0]);
				CFG_RANDOM_SEED: random_seed_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pixel_s1 <= '{frame_start: frame_start, blue: blue_in, green: green_in,
				red: red_in, payload: payload_byte};
		end
	end

	lpe_embed_calc u_calc (
		.pixel          (pixel_s1),
		.pos            (pos_q),
		.lfsr           (lfsr_q),
		.payload_length (payload_length_q),
		.fill_mode      (fill_mode_q),
		.random_seed    (random_seed_q),
		.result         (calc_result),
		.pos_next       (pos_next),
		.lfsr_next      (lfsr_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			lfsr_q <= LFSR_W'(1);
		end else if (adv_s1) begin
			pos_q <= pos_next;
			lfsr_q <= lfsr_next;
		end
	end

	lpe_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (adv_s1),
		.push_data (calc_result),
		.pop       (pop),
		.valid     (result_valid),
		.full      (fifo_full),
		.data      (fifo_data)
	);

	assign blue_out = fifo_data.blue;
	assign green_out = fifo_data.green;
	assign red_out = fifo_data.red;
	assign used_payload = fifo_data.used;

	a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		lfsr_q != '0)
		else $error("fill LFSR reached the all-zero state");

	a_no_overwrite_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> (!valid_s1 || adv_s1))
		else $error("input register overwritten before it advanced");

	a_pos_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && !pixel_s1.frame_start && pos_q == POS_MAX) |=> pos_q == POS_MAX)
		else $error("pixel position wrapped");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(fifo_data)))
		else $error("stalled result changed");

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
module testbench;
	import lpe_pkg::*;

	typedef enum int {RX_FREE, RX_RANDOM, RX_PATTERN} rx_style_t;

	logic             clk;
	logic             arst_n;
	logic             pixel_valid;
	logic             pixel_stall;
	logic             frame_start;
	logic [PIX_W-1:0] blue_in;
	logic [PIX_W-1:0] green_in;
	logic [PIX_W-1:0] red_in;
	logic [PIX_W-1:0] payload_byte;
	logic             result_valid;
	logic             result_stall;
	logic [PIX_W-1:0] blue_out;
	logic [PIX_W-1:0] green_out;
	logic [PIX_W-1:0] red_out;
	logic             used_payload;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [1:0]       cfg_index;
	logic [LEN_W-1:0] cfg_data;

	lsb_pixel_embed dut (.*);

	logic [LEN_W-1:0]  length_reg = 16'd1;
	fill_mode_t        fill_reg = FILL_NONE;
	logic [LEN_W-1:0]  seed_reg = 16'd1;
	logic [POS_W-1:0]  position = '0;
	logic [LFSR_W-1:0] fill_state = 16'd1;
	result_t           expected_pixels[$];

	int        error_count = 0;
	int        burst_left = 0;
	int        gap_max = 0;
	rx_style_t stall_style = RX_FREE;
	int        hold_ticket = 0;
	int        hold_served = 0;
	int        hold_left = 0;
	int        rx_cycle = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(12 * 1_500_000);
		$display("%0t: timeout, %0d results still pending", $time, expected_pixels.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic report_field(input string name, input logic [7:0] want, input logic [7:0] got);
		error_count++;
		$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
	endtask

	always @(posedge clk) begin
		result_t got;
		result_t want;
		got = {blue_out, green_out, red_out, used_payload};
		if (arst_n && result_valid && !result_stall) begin
			if (expected_pixels.size() == 0) begin
				error_count++;
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
			end else begin
				want = expected_pixels.pop_front();
				if (got.blue !== want.blue)
					report_field("blue_out", want.blue, got.blue);
				if (got.green !== want.green)
					report_field("green_out", want.green, got.green);
				if (got.red !== want.red)
					report_field("red_out", want.red, got.red);
				if (got.used !== want.used)
					report_field("used_payload", 8'(want.used), 8'(got.used));
			end
		end
		rx_cycle++;
		if (hold_ticket != hold_served) begin
			hold_served = hold_ticket;
			hold_left = 60;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			case (stall_style)
				RX_FREE: result_stall <= 1'b0;
				RX_RANDOM: result_stall <= ($urandom_range(0, 2) == 0);
				default: result_stall <= (rx_cycle % 7) < 3;
			endcase
		end
	end

	task automatic predict_pixel(input pixel_t px);
		logic [7:0] hidden;
		logic       embed;
		logic       used;
		result_t    r;
		hidden = '0;
		embed = 1'b1;
		used = 1'b0;
		if (px.frame_start) begin
			position = '0;
			fill_state = (seed_reg == '0) ? 16'd1 : seed_reg;
		end
		if (position == 0) begin
			hidden = length_reg[7:0];
		end else if (position == 1) begin
			hidden = length_reg[15:8];
		end else if (32'(position) < 32'(length_reg) + 2) begin
			hidden = px.payload;
			used = 1'b1;
		end else if (fill_reg == FILL_NONE) begin
			embed = 1'b0;
		end else begin
			fill_state = {1'b0, fill_state[15:1]} ^ (fill_state[0] ? LFSR_TAPS : '0);
			hidden = fill_state[7:0];
			if (fill_reg == FILL_DARK)
				hidden &= DARK_MASK;
			else if (fill_reg == FILL_LIGHT)
				hidden |= ~DARK_MASK;
		end
		r.blue = px.blue;
		r.green = px.green;
		r.red = px.red;
		if (embed) begin
			r.blue[2:0] = hidden[2:0];
			r.green[1:0] = hidden[4:3];
			r.red[2:0] = hidden[7:5];
		end
		r.used = used;
		if (position != POS_MAX)
			position++;
		expected_pixels.push_back(r);
	endtask

	task automatic send_pixel(input pixel_t px);
		if (gap_max > 0 && burst_left == 0) begin
			pixel_valid <= 1'b0;
			repeat ($urandom_range(1, gap_max)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left > 0)
			burst_left--;
		pixel_valid <= 1'b1;
		frame_start <= px.frame_start;
		blue_in <= px.blue;
		green_in <= px.green;
		red_in <= px.red;
		payload_byte <= px.payload;
		do @(posedge clk); while (pixel_stall);
		predict_pixel(px);
	endtask

	task automatic send_random(input logic fs);
		send_pixel('{fs, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)});
	endtask

	task automatic drain();
		pixel_valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [LEN_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_PAYLOAD_LENGTH: length_reg = value;
			CFG_FILL_MODE: fill_reg = fill_mode_t'(value[1:0]);
			CFG_RANDOM_SEED: seed_reg = value;
			default: ;
		endcase
	endtask

	task automatic configure(input logic [LEN_W-1:0] len, input fill_mode_t mode,
			input logic [LEN_W-1:0] seed);
		drain();
		write_reg(CFG_PAYLOAD_LENGTH, len);
		write_reg(CFG_FILL_MODE, {14'($urandom), mode});
		write_reg(CFG_RANDOM_SEED, seed);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_before_frame_start();
		send_pixel('{1'b0, 8'h00, 8'hFF, 8'h00, 8'hA5});
		send_pixel('{1'b0, 8'hFF, 8'h00, 8'hFF, 8'h00});
		send_pixel('{1'b0, 8'h00, 8'h00, 8'hFF, 8'hFF});
		send_pixel('{1'b0, 8'hFF, 8'hFF, 8'h00, 8'h3C});
		drain();
	endtask

	task automatic test_zero_seed();
		configure(16'd3, FILL_RANDOM, 16'h0000);
		for (int i = 0; i < 8; i++)
			send_pixel('{i == 0, (i % 2) ? 8'hFF : 8'h00, (i % 2) ? 8'h00 : 8'hFF,
				(i % 3) ? 8'hFF : 8'h00, (i % 2) ? 8'h00 : 8'hFF});
		drain();
	endtask

	task automatic test_fill_modes();
		fill_mode_t modes[3] = '{FILL_DARK, FILL_LIGHT, FILL_NONE};
		foreach (modes[m]) begin
			configure(16'd0, modes[m], 16'hFFFF);
			for (int i = 0; i < 3; i++)
				send_random(i == 0);
		end
		drain();
	endtask

	task automatic test_seed_mid_frame();
		configure(16'd2, FILL_LIGHT, 16'h1234);
		for (int i = 0; i < 3; i++)
			send_random(i == 0);
		configure(16'd0, FILL_RANDOM, 16'hBEEF);
		send_random(1'b0);
		send_random(1'b0);
		send_random(1'b1);
		drain();
	endtask

	task automatic test_backpressure();
		configure(16'($urandom_range(0, 10)), FILL_RANDOM, 16'($urandom_range(1, 16'hFFFF)));
		gap_max = 0;
		stall_style <= RX_FREE;
		hold_ticket <= hold_ticket + 1;
		for (int i = 0; i < 48; i++)
			send_random(i == 0);
		drain();
	endtask

	task automatic test_random_frames();
		logic [LEN_W-1:0] len;
		logic [LEN_W-1:0] seed;
		int               frame_left;
		int               gap_choices[3] = '{0, 3, 8};
		for (int phase = 0; phase < 10; phase++) begin
			case ($urandom_range(0, 7))
				0: len = 16'd0;
				1: len = 16'hFFFF;
				2: len = 16'($urandom);
				default: len = 16'($urandom_range(1, 20));
			endcase
			case ($urandom_range(0, 5))
				0: seed = 16'h0000;
				1: seed = 16'hFFFF;
				default: seed = 16'($urandom);
			endcase
			configure(len, fill_mode_t'($urandom_range(0, 3)), seed);
			gap_max = gap_choices[$urandom_range(0, 2)];
			stall_style <= rx_style_t'($urandom_range(0, 2));
			frame_left = 0;
			for (int i = 0; i < 110; i++) begin
				if (frame_left == 0) begin
					frame_left = $urandom_range(1, 40);
					send_random(1'b1);
				end else begin
					send_random($urandom_range(0, 63) == 0);
				end
				frame_left--;
			end
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		pixel_valid = 1'b0;
		frame_start = 1'b0;
		blue_in = '0;
		green_in = '0;
		red_in = '0;
		payload_byte = '0;
		result_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = CFG_PAYLOAD_LENGTH;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gap_max = 3;
		stall_style <= RX_RANDOM;
		test_before_frame_start();
		test_zero_seed();
		test_fill_modes();
		test_seed_mid_frame();
		test_backpressure();
		test_random_frames();
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### files.f
rtl/lpe_pkg.sv
rtl/lpe_embed_calc.sv
rtl/lpe_out_fifo.sv
rtl/lsb_pixel_embed.sv
tb/testbench.sv
